// File: rtl/core/bfpc_pkg.sv
// Shared constants, types and helpers for the box versus clip plane culling block.
package bfpc_pkg;

	// Sizing of the block.
	localparam int PLANE_COUNT = 4;
	localparam int MAX_CORNERS = 8;
	localparam int COORD_BITS  = 32;

	// Fixed widths of the stream fields.
	localparam int FIELD_W     = 32;
	localparam int INDEX_W     = 2;
	localparam int S_FIELDS_W  = INDEX_W + 6 * FIELD_W + 1;
	localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = 8;

	// Bit positions of the fields inside the slave tdata word.
	localparam int IDX_LSB     = 0;
	localparam int CX_LSB      = IDX_LSB + INDEX_W;
	localparam int CY_LSB      = CX_LSB + FIELD_W;
	localparam int CZ_LSB      = CY_LSB + FIELD_W;
	localparam int NX_LSB      = CZ_LSB + FIELD_W;
	localparam int NY_LSB      = NX_LSB + FIELD_W;
	localparam int NZ_LSB      = NY_LSB + FIELD_W;
	localparam int EMPTY_BIT   = NZ_LSB + FIELD_W;

	// Arithmetic widths: exact difference, exact product, exact three-term sum.
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int PROD_W      = DIFF_W + COORD_BITS;
	localparam int SUM2_W      = PROD_W + 1;
	localparam int SUM3_W      = PROD_W + 2;

	localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
	localparam int CELL_ID_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [CELL_ID_W-1:0]  cell_id_t;

	typedef enum logic {
		KIND_PLANE  = 1'b0,
		KIND_VERTEX = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_IN      = 2'd0,
		VERDICT_PARTIAL = 2'd1,
		VERDICT_OUT     = 2'd2
	} verdict_t;

	// One transaction as it moves down the row of plane cells.
	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [INDEX_W-1:0]  plane_index;
		coord_t [2:0]        coord;
		coord_t [2:0]        normal;
		logic                empty;
		logic                last;
		logic                counted;   // corner is within the corner limit
		cnt_t                seen;      // corners counted so far, this one included
		logic                any_out;
		logic                any_part;
	} token_t;

	function automatic verdict_t verdict_of(input logic any_out, input logic any_part);
		verdict_t v;
		if (any_out) begin
			v = VERDICT_OUT;
		end else if (any_part) begin
			v = VERDICT_PARTIAL;
		end else begin
			v = VERDICT_IN;
		end
		return v;
	endfunction

endpackage

// File: rtl/core/bfpc_cell.sv
// One plane cell: holds one clip plane and its behind count, tests each passing corner.
module bfpc_cell import bfpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  cell_id_t cell_id,
	input  token_t   tok_in,
	output token_t   tok_out
);

	coord_t [2:0]             point_q;
	coord_t [2:0]             normal_q;
	cnt_t                     count_q;

	token_t                   tok_s1, tok_s2, tok_s3, tok_s4;
	logic [2:0][DIFF_W-1:0]   diff_s1;
	coord_t [2:0]             nrm_s1;
	logic signed [PROD_W-1:0] prod0_s2, prod1_s2, prod2_s2;
	logic [SUM2_W-1:0]        sum01_s3;
	logic [PROD_W-1:0]        prod2_s3;

	logic [SUM3_W-1:0]        sum_all;
	logic                     behind;
	cnt_t                     cnt_new;
	logic                     hit;
	logic                     is_vertex_s3;
	token_t                   tok_upd;

	assign hit = tok_in.valid && (tok_in.kind == KIND_PLANE)
		&& (int'(tok_in.plane_index) == int'(cell_id));

	// Plane store; a plane transaction overwrites it as it passes this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q  <= '0;
			normal_q <= '0;
		end else if (advance && hit) begin
			point_q  <= tok_in.coord;
			normal_q <= tok_in.normal;
		end
	end

	// Stage 1: differences against the plane point, normal copied alongside.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int c = 0; c < 3; c++) begin
				diff_s1[c] <= {tok_in.coord[c][COORD_BITS-1], tok_in.coord[c]}
					- {point_q[c][COORD_BITS-1], point_q[c]};
				nrm_s1[c]  <= normal_q[c];
			end
		end
	end

	// Stage 2: three exact products.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod0_s2 <= $signed(diff_s1[0]) * $signed(nrm_s1[0]);
			prod1_s2 <= $signed(diff_s1[1]) * $signed(nrm_s1[1]);
			prod2_s2 <= $signed(diff_s1[2]) * $signed(nrm_s1[2]);
		end
	end

	// Stage 3: first partial sum.
	always_ff @(posedge clk) begin
		if (advance) begin
			sum01_s3 <= {prod0_s2[PROD_W-1], prod0_s2} + {prod1_s2[PROD_W-1], prod1_s2};
			prod2_s3 <= prod2_s2;
		end
	end

	// Stage 4: sign of the full distance and the count update.
	assign sum_all      = {sum01_s3[SUM2_W-1], sum01_s3} + {{2{prod2_s3[PROD_W-1]}}, prod2_s3};
	assign behind       = sum_all[SUM3_W-1];
	assign is_vertex_s3 = tok_s3.valid && (tok_s3.kind == KIND_VERTEX);
	assign cnt_new      = count_q + cnt_t'(tok_s3.counted && behind);

	// The final corner of a volume folds this plane into the verdict flags.
	always_comb begin
		tok_upd = tok_s3;
		if (is_vertex_s3 && !tok_s3.empty && tok_s3.last) begin
			tok_upd.any_out  = tok_s3.any_out || (cnt_new == tok_s3.seen);
			tok_upd.any_part = tok_s3.any_part || (cnt_new != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_s2  <= '0;
			tok_s3  <= '0;
			tok_s4  <= '0;
			count_q <= '0;
		end else if (advance) begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_upd;
			if (is_vertex_s3) begin
				if (tok_s3.empty || tok_s3.last) begin
					count_q <= '0;
				end else begin
					count_q <= cnt_new;
				end
			end
		end
	end

	assign tok_out = tok_s4;

endmodule

// File: rtl/core/box_frustum_plane_cull.sv
// Top level of the box versus clip plane culling block.
//
// The block classifies a box volume against PLANE_COUNT clip planes. A slave
// transaction with tuser low loads one plane (point and normal); one with tuser
// high carries one corner of the current volume, tlast marking its final corner.
// After the final corner a single master transaction carries the verdict:
// outside when every counted corner is behind one plane, partially inside when
// some plane has any corner behind it, inside otherwise. A corner transaction
// with the empty flag set yields outside at once and restarts the volume.
// Only the first MAX_CORNERS corners of a volume are counted. Distances are
// exact in signed Q16.16, so the answer never depends on rounding.
// The design is a row of identical plane cells; every transaction walks
// through all of them, each cell testing against its own plane and keeping
// its own behind count. A new transaction is taken every cycle while the row
// is not stalled; the path from slave acceptance to the verdict being shown
// runs through the input register, the four-stage difference, multiply and add
// pipeline in each cell, and the output register.
// The row stalls only when a verdict reaches its end while the previous
// verdict is still waiting in the output register.
module box_frustum_plane_cull import bfpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Fields from bit 0 up: plane_index[2], coord_x[32], coord_y[32], coord_z[32],
	// normal_x[32], normal_y[32], normal_z[32], volume_empty[1], zero fill.
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// Fields from bit 0 up: kind[1].
	input  logic                 s_axis_tuser,
	// last_vertex.
	input  logic                 s_axis_tlast,

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0 up: verdict[2], zero fill.
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	token_t   chain [PLANE_COUNT+1];
	token_t   tok_s0;
	token_t   tok_next;
	token_t   tail;
	cnt_t     corners_q;
	cnt_t     seen_next;
	logic     counted_next;
	logic     advance;
	logic     accept;
	logic     tail_result;
	logic     m_valid_q;
	verdict_t verdict_q;

	// The row moves unless a verdict would have to leave while the output is blocked.
	assign tail        = chain[PLANE_COUNT];
	assign tail_result = tail.valid && (tail.kind == KIND_VERTEX) && (tail.empty || tail.last);
	assign advance     = !(tail_result && m_valid_q && !m_axis_tready);
	assign s_axis_tready = advance;
	assign accept      = s_axis_tvalid && advance;

	// Corner counting is done once here; the cells only compare against it.
	assign counted_next = (corners_q < cnt_t'(MAX_CORNERS));
	assign seen_next    = counted_next ? corners_q + cnt_t'(1) : corners_q;

	always_comb begin
		tok_next             = '0;
		tok_next.valid       = accept;
		tok_next.kind        = kind_t'(s_axis_tuser);
		tok_next.plane_index = s_axis_tdata[IDX_LSB +: INDEX_W];
		tok_next.coord[0]    = s_axis_tdata[CX_LSB +: COORD_BITS];
		tok_next.coord[1]    = s_axis_tdata[CY_LSB +: COORD_BITS];
		tok_next.coord[2]    = s_axis_tdata[CZ_LSB +: COORD_BITS];
		tok_next.normal[0]   = s_axis_tdata[NX_LSB +: COORD_BITS];
		tok_next.normal[1]   = s_axis_tdata[NY_LSB +: COORD_BITS];
		tok_next.normal[2]   = s_axis_tdata[NZ_LSB +: COORD_BITS];
		tok_next.empty       = s_axis_tdata[EMPTY_BIT];
		tok_next.last        = s_axis_tlast;
		if (s_axis_tdata[EMPTY_BIT]) begin
			// An empty volume is outside no matter what the planes hold.
			tok_next.any_out = 1'b1;
		end else begin
			tok_next.counted = counted_next;
			tok_next.seen    = seen_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0    <= '0;
			corners_q <= '0;
		end else if (advance) begin
			tok_s0 <= tok_next;
			if (accept && (tok_next.kind == KIND_VERTEX)) begin
				if (tok_next.empty || tok_next.last) begin
					corners_q <= '0;
				end else begin
					corners_q <= seen_next;
				end
			end
		end
	end

	assign chain[0] = tok_s0;

	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
		bfpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.cell_id (cell_id_t'(k)),
			.tok_in  (chain[k]),
			.tok_out (chain[k+1])
		);
	end

	// Output register: holds one verdict until the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			verdict_q <= VERDICT_IN;
		end else if (advance && tail_result) begin
			m_valid_q <= 1'b1;
			verdict_q <= verdict_of(tail.any_out, tail.any_part);
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-2){1'b0}}, verdict_q};

endmodule
